// File: rtl/hpg_pkg.sv
// Shared constants, types and base tables for the Halton point generator.
package hpg_pkg;

  localparam int NUM_DIMENSIONS = 10;
  localparam int SAMPLE_BITS    = 14;
  localparam int FRACTION_BITS  = 32;   // even: the divider retires two bits a cycle
  localparam int OFFSET_WIDTH   = 20;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MODULUS = OFFSET_WIDTH'(1000000);

  localparam int DIM_BITS    = 4;
  localparam int BASE_BITS   = 5;
  localparam int RECIP_BITS  = 32;
  // sample + 1 + reduced offset stays below 2^(OFFSET_WIDTH+1)
  localparam int IDX_BITS    = OFFSET_WIDTH + 1;
  // base^n <= base * index
  localparam int DEN_BITS    = IDX_BITS + BASE_BITS;
  localparam int DIV_STEPS   = FRACTION_BITS / 2;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DIM_BITS-1:0] dim_t;

  // One dimension's reversed digits, handed from front to back.
  typedef struct packed {
    dim_t                dim;
    logic [DEN_BITS-1:0] rev;
    logic [DEN_BITS-1:0] den;
  } work_t;

  typedef enum logic [1:0] {F_IDLE, F_DIGIT, F_FOLD} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_HOLD} back_state_t;

  function automatic logic [BASE_BITS-1:0] prime_base(input dim_t d);
    logic [BASE_BITS-1:0] b;
    unique case (d)
      4'd0:    b = 5'd2;
      4'd1:    b = 5'd3;
      4'd2:    b = 5'd5;
      4'd3:    b = 5'd7;
      4'd4:    b = 5'd11;
      4'd5:    b = 5'd13;
      4'd6:    b = 5'd17;
      4'd7:    b = 5'd19;
      4'd8:    b = 5'd23;
      4'd9:    b = 5'd29;
      default: b = 5'd2;
    endcase
    return b;
  endfunction

  // floor(2^32 / base) + 1: quotient is exact for any index below 2^21
  function automatic logic [RECIP_BITS-1:0] prime_recip(input dim_t d);
    logic [RECIP_BITS-1:0] m;
    unique case (d)
      4'd0:    m = 32'd2147483649;
      4'd1:    m = 32'd1431655766;
      4'd2:    m = 32'd858993460;
      4'd3:    m = 32'd613566757;
      4'd4:    m = 32'd390451573;
      4'd5:    m = 32'd330382100;
      4'd6:    m = 32'd252645136;
      4'd7:    m = 32'd226050911;
      4'd8:    m = 32'd186737709;
      4'd9:    m = 32'd148102321;
      default: m = 32'd2147483649;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/halton_point_generator.sv
// Top level: Halton radical-inverse point generator over the first ten primes.
// The front end takes a new sample only once it has handed all ten dimensions to the queue;
//   the back end may still be dividing earlier ones (pop plus 16 two-bit divide steps
//   per dimension), and a result not yet popped holds the divider once it is done.
// Reset (rst, synchronous): offset clears to 0, queues and result slot empty.
module halton_point_generator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: index offset, reduced modulo one million on write
  input  logic                                cfg_write,
  input  logic [hpg_pkg::OFFSET_WIDTH-1:0]    cfg_data,
  // input item queue side
  input  logic [hpg_pkg::SAMPLE_BITS-1:0]     sample_number,
  input  logic                                push,
  output logic                                full,
  // result item queue side
  output logic [hpg_pkg::DIM_BITS-1:0]        dimension,
  output logic [hpg_pkg::FRACTION_BITS-1:0]   fraction,
  output logic                                last,
  output logic                                empty,
  input  logic                                pop
);
  import hpg_pkg::*;

  logic [OFFSET_WIDTH-1:0] index_offset;

  work_t front_data;
  logic  front_push;
  logic  queue_full;
  work_t back_data;
  logic  back_pop;
  logic  queue_empty;

  // Offset is stored already reduced, so the index add needs no compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_offset <= '0;
    end else if (cfg_write) begin
      if (cfg_data >= OFFSET_MODULUS) begin
        index_offset <= cfg_data - OFFSET_MODULUS;
      end else begin
        index_offset <= cfg_data;
      end
    end
  end

  // Front: index = sample + 1 + offset; per dimension, peel digits with a
  // reciprocal multiply and fold them into the reversed integer and base^n.
  hpg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_number (sample_number),
    .push          (push),
    .full          (full),
    .offset        (index_offset),
    .q_data        (front_data),
    .q_push        (front_push),
    .q_full        (queue_full)
  );

  // Decoupling queue: lets digit extraction run ahead of the divider.
  hpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_data),
    .wr_push  (front_push),
    .wr_full  (queue_full),
    .rd_data  (back_data),
    .rd_pop   (back_pop),
    .rd_empty (queue_empty)
  );

  // Back: floor(rev * 2^32 / base^n), result held in an output register so
  // the divider can start the next dimension while a result waits.
  hpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (back_data),
    .q_empty   (queue_empty),
    .q_pop     (back_pop),
    .dimension (dimension),
    .fraction  (fraction),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: rtl/hpg_front.sv
// Front end: takes a sample, peels base-b digits and builds the reversed integer per dimension.
module hpg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [hpg_pkg::SAMPLE_BITS-1:0]     sample_number,
  input  logic                                push,
  output logic                                full,
  input  logic [hpg_pkg::OFFSET_WIDTH-1:0]    offset,
  output hpg_pkg::work_t                      q_data,
  output logic                                q_push,
  input  logic                                q_full
);
  import hpg_pkg::*;

  front_state_t          state, state_next;
  logic [IDX_BITS-1:0]   start_idx, start_idx_next;
  logic [IDX_BITS-1:0]   idx, idx_next;
  logic [IDX_BITS-1:0]   quo, quo_next;
  logic [DEN_BITS-1:0]   rev, rev_next;
  logic [DEN_BITS-1:0]   den, den_next;
  dim_t                  dim, dim_next;

  logic [BASE_BITS-1:0]            base;
  logic [RECIP_BITS-1:0]           recip;
  logic [IDX_BITS+RECIP_BITS-1:0]  prod;
  logic [IDX_BITS+BASE_BITS-1:0]   quo_times_b;
  logic [IDX_BITS-1:0]             idx_rem;
  logic [DEN_BITS+BASE_BITS-1:0]   rev_times_b;
  logic [DEN_BITS+BASE_BITS-1:0]   den_times_b;
  logic [IDX_BITS-1:0]             new_idx;

  assign base  = prime_base(dim);
  assign recip = prime_recip(dim);

  // reciprocal multiply: quotient sits in the top bits
  assign prod = {{RECIP_BITS{1'b0}}, idx} * {{IDX_BITS{1'b0}}, recip};

  assign quo_times_b = {{BASE_BITS{1'b0}}, quo} * {{IDX_BITS{1'b0}}, base};
  assign idx_rem     = idx - quo_times_b[IDX_BITS-1:0];
  assign rev_times_b = {{BASE_BITS{1'b0}}, rev} * {{DEN_BITS{1'b0}}, base};
  assign den_times_b = {{BASE_BITS{1'b0}}, den} * {{DEN_BITS{1'b0}}, base};

  assign new_idx = IDX_BITS'(sample_number) + IDX_BITS'(offset) + IDX_BITS'(1);

  assign full       = (state != F_IDLE);
  assign q_data.dim = dim;
  assign q_data.rev = rev;
  assign q_data.den = den;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
    start_idx <= start_idx_next;
    idx       <= idx_next;
    quo       <= quo_next;
    rev       <= rev_next;
    den       <= den_next;
    dim       <= dim_next;
  end

  always_comb begin
    state_next     = state;
    start_idx_next = start_idx;
    idx_next       = idx;
    quo_next       = quo;
    rev_next       = rev;
    den_next       = den;
    dim_next       = dim;
    q_push         = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (push) begin
          start_idx_next = new_idx;
          idx_next       = new_idx;
          rev_next       = '0;
          den_next       = DEN_BITS'(1);
          dim_next       = '0;
          state_next     = F_DIGIT;
        end
      end
      F_DIGIT: begin
        if (idx == '0) begin
          // all digits out: hand the dimension to the back end
          if (!q_full) begin
            q_push = 1'b1;
            if (dim == dim_t'(NUM_DIMENSIONS - 1)) begin
              state_next = F_IDLE;
            end else begin
              dim_next = dim + dim_t'(1);
              idx_next = start_idx;
              rev_next = '0;
              den_next = DEN_BITS'(1);
            end
          end
        end else begin
          quo_next   = prod[IDX_BITS+RECIP_BITS-1:RECIP_BITS];
          state_next = F_FOLD;
        end
      end
      F_FOLD: begin
        idx_next   = quo;
        rev_next   = rev_times_b[DEN_BITS-1:0] + DEN_BITS'(idx_rem[BASE_BITS-1:0]);
        den_next   = den_times_b[DEN_BITS-1:0];
        state_next = F_DIGIT;
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

// File: rtl/hpg_queue.sv
// Small FIFO of reversed-digit items between the front and back ends.
module hpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  hpg_pkg::work_t wr_data,
  input  logic           wr_push,
  output logic           wr_full,
  output hpg_pkg::work_t rd_data,
  input  logic           rd_pop,
  output logic           rd_empty
);
  import hpg_pkg::*;

  work_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign rd_empty = (count == '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_push && !wr_full;
  assign do_rd    = rd_pop && !rd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_BITS'(1);
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/hpg_back.sv
// Back end: restoring division of the reversed integer by base^n, two bits per cycle.
module hpg_back (
  input  logic                               clk,
  input  logic                               rst,
  input  hpg_pkg::work_t                     q_data,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic [hpg_pkg::DIM_BITS-1:0]       dimension,
  output logic [hpg_pkg::FRACTION_BITS-1:0]  fraction,
  output logic                               last,
  output logic                               empty,
  input  logic                               pop
);
  import hpg_pkg::*;

  back_state_t               state, state_next;
  logic [DEN_BITS-1:0]       rem, rem_next;
  logic [DEN_BITS-1:0]       den, den_next;
  logic [FRACTION_BITS-1:0]  quot, quot_next;
  logic [STEP_BITS-1:0]      step, step_next;
  dim_t                      dim, dim_next;

  logic                      out_valid;
  logic                      out_load;
  logic [FRACTION_BITS-1:0]  out_frac_src;
  logic                      out_free;

  logic [DEN_BITS:0]         t1, t2;
  logic                      ge1, ge2;
  logic [DEN_BITS-1:0]       r1, r2;

  // two dependent restoring steps
  assign t1  = {rem, 1'b0};
  assign ge1 = (t1 >= {1'b0, den});
  assign r1  = ge1 ? DEN_BITS'(t1 - {1'b0, den}) : t1[DEN_BITS-1:0];
  assign t2  = {r1, 1'b0};
  assign ge2 = (t2 >= {1'b0, den});
  assign r2  = ge2 ? DEN_BITS'(t2 - {1'b0, den}) : t2[DEN_BITS-1:0];

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    rem  <= rem_next;
    den  <= den_next;
    quot <= quot_next;
    step <= step_next;
    dim  <= dim_next;
    if (out_load) begin
      dimension <= dim;
      fraction  <= out_frac_src;
      last      <= (dim == dim_t'(NUM_DIMENSIONS - 1));
    end
  end

  always_comb begin
    state_next   = state;
    rem_next     = rem;
    den_next     = den;
    quot_next    = quot;
    step_next    = step;
    dim_next     = dim;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    out_frac_src = quot;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          rem_next   = q_data.rev;
          den_next   = q_data.den;
          dim_next   = q_data.dim;
          quot_next  = '0;
          step_next  = '0;
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        rem_next  = r2;
        quot_next = {quot[FRACTION_BITS-3:0], ge1, ge2};
        step_next = step + STEP_BITS'(1);
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_frac_src = {quot[FRACTION_BITS-3:0], ge1, ge2};
            state_next   = B_IDLE;
          end else begin
            state_next = B_HOLD;
          end
        end
      end
      B_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule
